// ===== src/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, constants and PEC functions of the cell balancing mask block.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int MaskW = 12;
  localparam int VoltW = 16;
  localparam int DiffW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  typedef logic [VoltW-1:0] volt_t;
  typedef logic [MaskW-1:0] mask_t;
  typedef logic [15:0] pec_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_VOLTAGE_LIMIT     = 3'd0,
    REG_BALANCE_VOLTAGE_LIMIT = 3'd1,
    REG_ALLOWED_DIFFERENCE    = 3'd2,
    REG_TEMPERATURE_LIMIT     = 3'd3
  } cfg_reg_t;

  localparam volt_t LOW_VOLTAGE_RESET = 16'd3000;
  localparam volt_t BALANCE_VOLTAGE_RESET = 16'd4150;
  localparam logic [DiffW-1:0] ALLOWED_DIFFERENCE_RESET = 8'd10;
  localparam volt_t TEMPERATURE_RESET = 16'd60;

  localparam pec_t PEC_POLY = 16'h4599;
  localparam pec_t PEC_SEED = 16'd16;
  localparam logic [7:0] PEC_CMD_BYTE = 8'hF8;

  // One byte-wise CRC15 table entry.
  function automatic pec_t pec_entry(input logic [7:0] idx);
    pec_t r;
    r = {1'b0, idx, 7'b0};
    for (int k = 0; k < 8; k++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Fold one byte into the running remainder.
  function automatic pec_t pec_byte(input pec_t rem, input logic [7:0] data);
    logic [7:0] idx;
    idx = rem[14:7] ^ data;
    return {rem[7:0], 8'h00} ^ pec_entry(idx);
  endfunction

  // Remainder after the command byte and the three zero bytes.
  function automatic pec_t pec_prefix();
    pec_t rem;
    rem = pec_byte(PEC_SEED, PEC_CMD_BYTE);
    rem = pec_byte(rem, 8'h00);
    rem = pec_byte(rem, 8'h00);
    rem = pec_byte(rem, 8'h00);
    return rem;
  endfunction

  localparam pec_t PEC_PREFIX_REM = pec_prefix();

  // Complete PEC word for a mask, already shifted left by one.
  function automatic pec_t pec_of_mask(input mask_t mask);
    pec_t rem;
    rem = pec_byte(PEC_PREFIX_REM, mask[7:0]);
    rem = pec_byte(rem, {4'b0000, mask[11:8]});
    return {rem[14:0], 1'b0};
  endfunction

endpackage

// ===== src/cell_balance_mask_with_crc15.sv =====
// ----------------------------------------------------------------------------
// cell_balance_mask_with_crc15
// Builds the cell discharge mask of one pack and its CRC15 packet error code.
// ----------------------------------------------------------------------------
// Cells arrive in order, one per transaction, each with the pack minimum and
// the hottest balancing temperature. The block takes one transaction every
// clock cycle: a cell is captured in an input register, decided and folded
// into the running mask in the next cycle, and after the last of the CELLS
// cells the finished mask and its PEC word are loaded from the input
// register into the result register. The result register separates the
// two sides, so cells keep flowing while a result waits; only the last
// cell of a pack is held back, and only when the previous result is still
// stalled. Configuration registers are written through their own channel,
// which is always ready, and must only be written while the block is idle.
module cell_balance_mask_with_crc15
  import cbm_pkg::*;
#(
  parameter int CELLS = 12
) (
  input  logic                clk,
  input  logic                rst,
  // Cell input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VoltW-1:0]    cell_voltage,
  input  logic [VoltW-1:0]    min_cell_voltage,
  input  logic [VoltW-1:0]    hottest_temp,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MaskW-1:0]    discharge_mask,
  output logic [15:0]         pec_word,
  // Configuration write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Width of the cell position counter; at least one bit.
  localparam int PosW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(CELLS - 1);

  // Configuration registers.
  volt_t            low_voltage_limit;
  volt_t            balance_voltage_limit;
  logic [DiffW-1:0] allowed_difference;
  volt_t            temperature_limit;

  // Input register.
  logic  in_reg_valid;
  volt_t in_cell;
  volt_t in_min;
  volt_t in_temp;

  // Pack state.
  mask_t           mask_so_far;
  logic [PosW-1:0] pos;

  logic  last_cell;
  logic  result_free;
  logic  advance;
  logic  in_take;
  volt_t diff;
  logic  balance;
  mask_t mask_next;

  assign cfg_ready = 1'b1;

  // The configuration channel never stalls; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_voltage_limit     <= LOW_VOLTAGE_RESET;
      balance_voltage_limit <= BALANCE_VOLTAGE_RESET;
      allowed_difference    <= ALLOWED_DIFFERENCE_RESET;
      temperature_limit     <= TEMPERATURE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW_VOLTAGE_LIMIT:     low_voltage_limit     <= cfg_data;
        REG_BALANCE_VOLTAGE_LIMIT: balance_voltage_limit <= cfg_data;
        REG_ALLOWED_DIFFERENCE:    allowed_difference    <= cfg_data[DiffW-1:0];
        REG_TEMPERATURE_LIMIT:     temperature_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The last cell of a pack needs room in the result register; every other
  // cell moves on at once.
  assign last_cell   = (pos == LastPos);
  assign result_free = !out_valid || !out_stall;
  assign advance     = in_reg_valid && (!last_cell || result_free);
  assign in_stall    = in_reg_valid && !advance;
  assign in_take     = in_valid && !in_stall;

  // The difference wraps at 16 bits, so a cell below the minimum reads as a
  // large excess.
  assign diff    = in_cell - in_min;
  assign balance = (in_cell > low_voltage_limit) &&
                   (in_temp < temperature_limit) &&
                   ((in_cell > balance_voltage_limit) ||
                    (diff > {{(VoltW-DiffW){1'b0}}, allowed_difference}));
  assign mask_next = mask_so_far | (MaskW'(balance) << pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cell <= cell_voltage;
      in_min  <= min_cell_voltage;
      in_temp <= hottest_temp;
    end
  end

  // Running mask and position; both restart once a pack is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_so_far <= '0;
      pos         <= '0;
    end else if (advance) begin
      if (last_cell) begin
        mask_so_far <= '0;
        pos         <= '0;
      end else begin
        mask_so_far <= mask_next;
        pos         <= pos + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_cell) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_cell) begin
      discharge_mask <= mask_next;
      pec_word       <= pec_of_mask(mask_next);
    end
  end

`ifndef SYNTHESIS
  // The position never runs past the last cell of a pack.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LastPos)
    else $error("cell position beyond the last cell");

  // A completed pack leaves the state cleared for the next one.
  a_pack_restart: assert property (@(posedge clk) disable iff (rst)
    advance && last_cell |=> pos == '0 && mask_so_far == '0)
    else $error("pack state not cleared after the last cell");

  // The PEC word shown always belongs to the mask shown with it.
  a_pec_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pec_word == pec_of_mask(discharge_mask))
    else $error("PEC word does not match the discharge mask");

  // The last cell is only held back by a result that cannot leave.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && last_cell && out_valid && out_stall)
    else $error("input stalled without a waiting result");
`endif

endmodule

// ===== sim/cbm_pack_checker.sv =====
// ----------------------------------------------------------------------------
// cbm_pack_checker
// Predicts the discharge mask and PEC word of every pack and checks the block.
// ----------------------------------------------------------------------------
module cbm_pack_checker
  import cbm_pkg::*;
#(
  parameter int CELLS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [VoltW-1:0]    cell_voltage,
  input  logic [VoltW-1:0]    min_cell_voltage,
  input  logic [VoltW-1:0]    hottest_temp,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [MaskW-1:0]    discharge_mask,
  input  logic [15:0]         pec_word,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int unsigned         fail_count,
  output int unsigned         packs_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mask_t mask;
    pec_t  pec;
  } pack_result_t;

  pack_result_t      pack_results_due[$];

  volt_t             low_lim;
  volt_t             bal_lim;
  logic [DiffW-1:0]  diff_allow;
  volt_t             temp_lim;

  mask_t             mask_acc;
  logic [3:0]        next_cell;

  // Bit-serial CRC15 over the six-byte frame, remainder kept at 15 bits.
  function automatic pec_t crc15_pec(input mask_t mask);
    logic [47:0] frame;
    logic [14:0] rem;
    logic        fb;
    frame = {PEC_CMD_BYTE, 24'h000000, mask[7:0], 4'h0, mask[11:8]};
    rem = PEC_SEED[14:0];
    for (int i = 47; i >= 0; i--) begin
      fb = frame[i] ^ rem[14];
      rem = {rem[13:0], 1'b0};
      if (fb) begin
        rem = rem ^ PEC_POLY[14:0];
      end
    end
    return {rem, 1'b0};
  endfunction

  // The excess over the pack minimum wraps at 16 bits.
  function automatic logic discharge_wanted(input volt_t v, input volt_t vmin,
                                            input volt_t t);
    volt_t excess;
    excess = v - vmin;
    return (v > low_lim) && (t < temp_lim) &&
           ((v > bal_lim) || (excess > volt_t'(diff_allow)));
  endfunction

  always @(posedge clk) begin : track
    pack_result_t due;
    if (rst) begin
      low_lim = LOW_VOLTAGE_RESET;
      bal_lim = BALANCE_VOLTAGE_RESET;
      diff_allow = ALLOWED_DIFFERENCE_RESET;
      temp_lim = TEMPERATURE_RESET;
      mask_acc = '0;
      next_cell = '0;
      pack_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pack_results_due.size() == 0) begin
          $display("%0t ns: result with none expected, mask %03h pec %04h",
                   $time, discharge_mask, pec_word);
          fail_count++;
        end else begin
          due = pack_results_due.pop_front();
          if (discharge_mask !== due.mask) begin
            $display("%0t ns: discharge_mask expected %03h, got %03h",
                     $time, due.mask, discharge_mask);
            fail_count++;
          end
          if (pec_word !== due.pec) begin
            $display("%0t ns: pec_word expected %04h, got %04h",
                     $time, due.pec, pec_word);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_VOLTAGE_LIMIT:     low_lim = cfg_data;
          REG_BALANCE_VOLTAGE_LIMIT: bal_lim = cfg_data;
          REG_ALLOWED_DIFFERENCE:    diff_allow = cfg_data[DiffW-1:0];
          REG_TEMPERATURE_LIMIT:     temp_lim = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (discharge_wanted(cell_voltage, min_cell_voltage, hottest_temp) &&
            int'(next_cell) < MaskW) begin
          mask_acc[next_cell] = 1'b1;
        end
        if (int'(next_cell) + 1 >= CELLS) begin
          pack_results_due.push_back('{mask: mask_acc, pec: crc15_pec(mask_acc)});
          mask_acc = '0;
          next_cell = '0;
        end else begin
          next_cell = next_cell + 4'd1;
        end
      end
    end
    packs_outstanding = pack_results_due.size();
  end

endmodule

// ===== sim/tb_cell_balance_mask_with_crc15.sv =====
// ----------------------------------------------------------------------------
// tb_cell_balance_mask_with_crc15
// Drives packs of cells and register settings into the balancing mask block.
// ----------------------------------------------------------------------------
// The top makes the stimulus and gives the verdict; a checker beside the
// block watches every channel, predicts each pack's mask and PEC word, and
// reports mismatches. Two directed packs come first, then a series of
// phases, each under its own register setting, filled with random cells
// that sit close to the programmed limits so that mask bits turn on and off.
// ----------------------------------------------------------------------------
module tb_cell_balance_mask_with_crc15
  import cbm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = 12;
  localparam int PHASES = 9;
  localparam int PACKS_PER_PHASE = 12;
  // Indexes from here to the top of the index range address no register.
  localparam logic [CfgIdxW-1:0] REG_UNUSED_FIRST = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LAST = 3'd7;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [VoltW-1:0]    cell_voltage;
  logic [VoltW-1:0]    min_cell_voltage;
  logic [VoltW-1:0]    hottest_temp;
  logic                out_valid;
  logic                out_stall;
  logic [MaskW-1:0]    discharge_mask;
  logic [15:0]         pec_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned         fail_count;
  int unsigned         packs_outstanding;

  // When set, neither side idles: back-to-back transactions in both directions.
  logic                quiet;

  // The current register setting, kept here only to steer the random cells
  // towards the thresholds.
  volt_t               cfg_low;
  volt_t               cfg_bal;
  logic [DiffW-1:0]    cfg_diff;
  volt_t               cfg_temp;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cell_balance_mask_with_crc15 #(
    .CELLS(CELLS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cell_voltage     (cell_voltage),
    .min_cell_voltage (min_cell_voltage),
    .hottest_temp     (hottest_temp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .discharge_mask   (discharge_mask),
    .pec_word         (pec_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cbm_pack_checker #(
    .CELLS(CELLS)
  ) checker_i (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .cell_voltage      (cell_voltage),
    .min_cell_voltage  (min_cell_voltage),
    .hottest_temp      (hottest_temp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .discharge_mask    (discharge_mask),
    .pec_word          (pec_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .packs_outstanding (packs_outstanding)
  );

  // Length of an idle stretch, in cycles. Most are nil or short, a few are
  // long, and in quiet phases there are none at all.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // One register write on the configuration channel. Inputs change on the
  // falling edge; the write takes effect at the rising edge where valid and
  // ready are both high.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Programmes all four registers and adds one write to an index outside the
  // register list, which the block must ignore. The allowed difference is
  // written as a full data word so that its upper bits are thrown away.
  task automatic apply_setting(input volt_t low, input volt_t bal,
                               input logic [CfgDataW-1:0] diff_word,
                               input volt_t temp);
    write_reg(REG_BALANCE_VOLTAGE_LIMIT, bal);
    write_reg(REG_UNUSED_FIRST + CfgIdxW'($urandom_range(0,
              int'(REG_UNUSED_LAST - REG_UNUSED_FIRST))), CfgDataW'($urandom));
    write_reg(REG_LOW_VOLTAGE_LIMIT, low);
    write_reg(REG_TEMPERATURE_LIMIT, temp);
    write_reg(REG_ALLOWED_DIFFERENCE, diff_word);
    cfg_low = low;
    cfg_bal = bal;
    cfg_diff = diff_word[DiffW-1:0];
    cfg_temp = temp;
  endtask

  // Sends one cell transaction after a random gap. Valid stays high from one
  // transaction to the next when there is no gap, and the payload is held
  // while the block stalls.
  task automatic send_cell(input volt_t v, input volt_t vmin, input volt_t t);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    cell_voltage = v;
    min_cell_voltage = vmin;
    hottest_temp = t;
    do @(posedge clk); while (in_stall);
  endtask

  // A random cell. A fifth of them are fully random, which also exercises
  // every bit of each field; the rest sit within a few millivolts of the low
  // or balance limit, with a pack minimum just either side of the allowed
  // difference (sometimes above the cell, so that the difference wraps) and a
  // temperature around or below the limit.
  task automatic send_random_cell();
    volt_t v;
    volt_t vmin;
    volt_t t;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      v = volt_t'($urandom);
      vmin = volt_t'($urandom);
      t = volt_t'($urandom);
    end else begin
      v = ((pick < 6) ? cfg_low : cfg_bal) + volt_t'($urandom_range(0, 8)) - volt_t'(4);
      if ($urandom_range(0, 7) == 0) begin
        vmin = v + volt_t'($urandom_range(1, 50));
      end else begin
        vmin = v - volt_t'($urandom_range(0, 2 * int'(cfg_diff) + 2));
      end
      if ($urandom_range(0, 4) == 0) begin
        t = cfg_temp + volt_t'($urandom_range(0, 4)) - volt_t'(2);
      end else begin
        t = volt_t'($urandom_range(0, int'(cfg_temp)));
      end
    end
    send_cell(v, vmin, t);
  endtask

  // Drops valid and holds the sender back until every pack result has been
  // taken, then lets the block's pipeline drain before anything else happens.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (packs_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The result side stalls in random stretches, independently of whether a
  // result is waiting, so that stalls land on every stage of the block.
  initial begin : result_stall
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    quiet = 1'b0;
    in_valid = 1'b0;
    cell_voltage = '0;
    min_cell_voltage = '0;
    hottest_temp = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LOW_VOLTAGE_LIMIT;
    cfg_data = '0;
    cfg_low = LOW_VOLTAGE_RESET;
    cfg_bal = BALANCE_VOLTAGE_RESET;
    cfg_diff = ALLOWED_DIFFERENCE_RESET;
    cfg_temp = TEMPERATURE_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // First directed pack, under the reset setting (low 3000, balance 4150,
    // difference 10, temperature 60): field extremes, each threshold hit
    // exactly and just passed, and a cell below the pack minimum, whose
    // difference wraps round to a large value.
    send_cell(16'd0, 16'd0, 16'd0);
    send_cell(16'hFFFF, 16'hFFFF, 16'd0);
    send_cell(16'd3000, 16'd0, 16'd0);
    send_cell(16'd3001, 16'd2991, 16'd0);
    send_cell(16'd3001, 16'd2990, 16'd0);
    send_cell(16'd4150, 16'd4150, 16'd0);
    send_cell(16'd4151, 16'd4151, 16'd59);
    send_cell(16'd4151, 16'd4151, 16'd60);
    send_cell(16'd3500, 16'd3600, 16'd10);
    send_cell(16'hFFFF, 16'd0, 16'hFFFF);
    send_cell(16'h5555, 16'hAAAA, 16'd0);
    send_cell(16'hAAAA, 16'h5555, 16'd0);

    // Second directed pack: every cell is discharged, giving a full mask.
    for (int i = 0; i < CELLS; i++) begin
      send_cell(16'hFFFF - volt_t'(i), volt_t'(i), volt_t'(i));
    end
    settle();

    // Random phases. The first three settings are the extremes: everything
    // at zero (no temperature can be below zero, so nothing balances),
    // everything at its maximum, and wide open limits where almost every
    // cell balances.
    for (int phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 3) || (phase == 6);
      case (phase)
        0: apply_setting(16'h0000, 16'h0000, 16'hFF00, 16'h0000);
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_setting(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        default: begin
          apply_setting(volt_t'($urandom_range(2000, 3600)),
                        volt_t'($urandom_range(3400, 4400)),
                        CfgDataW'($urandom),
                        ($urandom_range(0, 3) == 0) ? volt_t'($urandom)
                                                    : volt_t'($urandom_range(20, 90)));
        end
      endcase
      for (int pack = 0; pack < PACKS_PER_PHASE; pack++) begin
        for (int c = 0; c < CELLS; c++) begin
          send_random_cell();
        end
        // Now and then the sender waits for the block to empty completely
        // before the next pack.
        if ($urandom_range(0, 7) == 0) begin
          settle();
        end
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && packs_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: the slowest legal run needs well under a tenth of this.
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
